// File: rtl/triangle_barycentric_coords_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barycentric coordinate block
// Concurrent checks on the block's own pipeline logic; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_COORDS_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TBC_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("barycentric block: same-cycle check failed");

// Next-cycle implication.
`define TBC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("barycentric block: next-cycle check failed");

`else

`define TBC_ASSERT_IMPL(label, clock, reset, ante, cons)

`define TBC_ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

// File: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Widths, types and constants shared by the barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int COORD_W = 32;   // coordinate and weight fields
  localparam int DIFF_W  = 33;   // exact vertex differences
  localparam int PROD_W  = 66;   // product of two differences
  localparam int DOT_W   = 67;   // signed dot product
  localparam int MAG_W   = 66;   // dot product magnitude
  localparam int HALF_W  = 33;   // half of a magnitude for split multiply
  localparam int WIDE_W  = 132;  // product of two magnitudes, also the divisor
  localparam int NUM_W   = 134;  // signed numerator before scaling

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [WIDE_W-1:0]         wide_t;

  // Control bits that travel with an item through the division stages.
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg_v;
    logic neg_w;
  } tbc_ctl_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

// File: rtl/tbc_dot.sv
// ----------------------------------------------------------------------------
// tbc_dot
// Edge vectors and the five dot products, three register stages.
// ----------------------------------------------------------------------------
module tbc_dot
  import tbc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   item_valid,
  input  coord_t pt [3],
  input  coord_t va [3],
  input  coord_t vb [3],
  input  coord_t vc [3],
  output logic   dot_valid,
  output dot_t   d00,
  output dot_t   d01,
  output dot_t   d11,
  output dot_t   d20,
  output dot_t   d21
);

  diff_t e0 [3];
  diff_t e1 [3];
  diff_t e2 [3];
  logic  s1_valid;
  logic  s2_valid;
  logic signed [PROD_W-1:0] p00 [3];
  logic signed [PROD_W-1:0] p01 [3];
  logic signed [PROD_W-1:0] p11 [3];
  logic signed [PROD_W-1:0] p20 [3];
  logic signed [PROD_W-1:0] p21 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      dot_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= item_valid;
      s2_valid  <= s1_valid;
      dot_valid <= s2_valid;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0[k]  <= DIFF_W'(vb[k]) - DIFF_W'(va[k]);
        e1[k]  <= DIFF_W'(vc[k]) - DIFF_W'(va[k]);
        e2[k]  <= DIFF_W'(pt[k]) - DIFF_W'(va[k]);
        p00[k] <= e0[k] * e0[k];
        p01[k] <= e0[k] * e1[k];
        p11[k] <= e1[k] * e1[k];
        p20[k] <= e2[k] * e0[k];
        p21[k] <= e2[k] * e1[k];
      end
      d00 <= DOT_W'(p00[0]) + DOT_W'(p00[1]) + DOT_W'(p00[2]);
      d01 <= DOT_W'(p01[0]) + DOT_W'(p01[1]) + DOT_W'(p01[2]);
      d11 <= DOT_W'(p11[0]) + DOT_W'(p11[1]) + DOT_W'(p11[2]);
      d20 <= DOT_W'(p20[0]) + DOT_W'(p20[1]) + DOT_W'(p20[2]);
      d21 <= DOT_W'(p21[0]) + DOT_W'(p21[1]) + DOT_W'(p21[2]);
    end
  end

endmodule

// File: rtl/tbc_wmul.sv
// ----------------------------------------------------------------------------
// tbc_wmul
// Unsigned 66 x 66 multiplier built from four 33 x 33 partial products,
// two register stages.
// ----------------------------------------------------------------------------
module tbc_wmul
  import tbc_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  mag_t  x,
  input  mag_t  y,
  output wide_t prod
);

  logic [PROD_W-1:0] pp_ll;
  logic [PROD_W-1:0] pp_lh;
  logic [PROD_W-1:0] pp_hl;
  logic [PROD_W-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= x[HALF_W-1:0]     * y[HALF_W-1:0];
      pp_lh <= x[HALF_W-1:0]     * y[MAG_W-1:HALF_W];
      pp_hl <= x[MAG_W-1:HALF_W] * y[HALF_W-1:0];
      pp_hh <= x[MAG_W-1:HALF_W] * y[MAG_W-1:HALF_W];
      prod  <= WIDE_W'(pp_ll)
             + (WIDE_W'(pp_lh) << HALF_W)
             + (WIDE_W'(pp_hl) << HALF_W)
             + (WIDE_W'(pp_hh) << (2 * HALF_W));
    end
  end

endmodule

// File: rtl/tbc_cross.sv
// ----------------------------------------------------------------------------
// tbc_cross
// Forms the denominator and both scaled numerator magnitudes from the dot
// products, five register stages.
// ----------------------------------------------------------------------------
module tbc_cross
  import tbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     dot_valid,
  input  dot_t                     d00,
  input  dot_t                     d01,
  input  dot_t                     d11,
  input  dot_t                     d20,
  input  dot_t                     d21,
  output tbc_ctl_t                 ctl,
  output wide_t                    denom,
  output logic [NUM_W-2+FRAC_BITS:0] num_v,
  output logic [NUM_W-2+FRAC_BITS:0] num_w
);

  logic  v4, v5, v6, v7;
  mag_t  m00, m01, m11, m20, m21;
  logic  s01, s20, s21;
  // Signs of the four numerator products, delayed to meet the multipliers.
  logic [3:0] sg5, sg6;
  mag_t  mul_x [6];
  mag_t  mul_y [6];
  wide_t prod  [6];
  wide_t denom_r;
  logic signed [NUM_W-1:0] nv, nw;
  logic signed [NUM_W-1:0] nv_abs, nw_abs;

  function automatic logic signed [NUM_W-1:0] signed_of(wide_t m, logic neg);
    logic signed [NUM_W-1:0] val;
    val = $signed({2'b00, m});
    return neg ? -val : val;
  endfunction

  assign mul_x[0] = m00;  assign mul_y[0] = m11;
  assign mul_x[1] = m01;  assign mul_y[1] = m01;
  assign mul_x[2] = m11;  assign mul_y[2] = m20;
  assign mul_x[3] = m01;  assign mul_y[3] = m21;
  assign mul_x[4] = m00;  assign mul_y[4] = m21;
  assign mul_x[5] = m01;  assign mul_y[5] = m20;

  for (genvar g = 0; g < 6; g++) begin : g_mul
    tbc_wmul u_wmul (
      .clk  (clk),
      .en   (en),
      .x    (mul_x[g]),
      .y    (mul_y[g]),
      .prod (prod[g])
    );
  end

  assign nv_abs = nv[NUM_W-1] ? -nv : nv;
  assign nw_abs = nw[NUM_W-1] ? -nw : nw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v4 <= dot_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      ctl.valid <= v7;
    end
    if (en) begin
      // d00 and d11 are sums of squares and never negative.
      m00 <= d00[MAG_W-1:0];
      m11 <= d11[MAG_W-1:0];
      m01 <= d01[DOT_W-1] ? MAG_W'(-d01) : MAG_W'(d01);
      m20 <= d20[DOT_W-1] ? MAG_W'(-d20) : MAG_W'(d20);
      m21 <= d21[DOT_W-1] ? MAG_W'(-d21) : MAG_W'(d21);
      s01 <= d01[DOT_W-1];
      s20 <= d20[DOT_W-1];
      s21 <= d21[DOT_W-1];
      sg5 <= {s01 ^ s20, s21, s01 ^ s21, s20};
      sg6 <= sg5;
      denom_r <= prod[0] - prod[1];
      nv <= signed_of(prod[2], sg6[0]) - signed_of(prod[3], sg6[1]);
      nw <= signed_of(prod[4], sg6[2]) - signed_of(prod[5], sg6[3]);
      ctl.degen <= (denom_r == '0);
      ctl.neg_v <= nv[NUM_W-1];
      ctl.neg_w <= nw[NUM_W-1];
      denom <= denom_r;
      num_v <= {nv_abs[NUM_W-2:0], {FRAC_BITS{1'b0}}};
      num_w <= {nw_abs[NUM_W-2:0], {FRAC_BITS{1'b0}}};
    end
  end

endmodule

// File: rtl/tbc_div_step.sv
// ----------------------------------------------------------------------------
// tbc_div_step
// One restoring division stage for both weights: produces one quotient bit
// of v and of w and registers the partial remainders.
// ----------------------------------------------------------------------------
module tbc_div_step
  import tbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  tbc_ctl_t                   ctl_in,
  input  wide_t                      div_in,
  input  wide_t                      rem_v_in,
  input  wide_t                      rem_w_in,
  input  logic [NUM_W-2+FRAC_BITS:0] nq_v_in,
  input  logic [NUM_W-2+FRAC_BITS:0] nq_w_in,
  output tbc_ctl_t                   ctl_out,
  output wide_t                      div_out,
  output wide_t                      rem_v_out,
  output wide_t                      rem_w_out,
  output logic [NUM_W-2+FRAC_BITS:0] nq_v_out,
  output logic [NUM_W-2+FRAC_BITS:0] nq_w_out
);

  localparam int QUO_W = NUM_W - 1 + FRAC_BITS;

  // The numerator leaves at the top of nq while quotient bits enter below.
  logic [WIDE_W:0]   trial_v, trial_w;
  logic [WIDE_W+1:0] diff_v, diff_w;
  logic              ge_v, ge_w;

  assign trial_v = {rem_v_in, nq_v_in[QUO_W-1]};
  assign trial_w = {rem_w_in, nq_w_in[QUO_W-1]};
  assign diff_v  = {1'b0, trial_v} - {2'b00, div_in};
  assign diff_w  = {1'b0, trial_w} - {2'b00, div_in};
  assign ge_v    = ~diff_v[WIDE_W+1];
  assign ge_w    = ~diff_w[WIDE_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.degen <= ctl_in.degen;
      ctl_out.neg_v <= ctl_in.neg_v;
      ctl_out.neg_w <= ctl_in.neg_w;
      div_out   <= div_in;
      rem_v_out <= ge_v ? diff_v[WIDE_W-1:0] : trial_v[WIDE_W-1:0];
      rem_w_out <= ge_w ? diff_w[WIDE_W-1:0] : trial_w[WIDE_W-1:0];
      nq_v_out  <= {nq_v_in[QUO_W-2:0], ge_v};
      nq_w_out  <= {nq_w_in[QUO_W-2:0], ge_w};
    end
  end

endmodule

// File: rtl/triangle_barycentric_coords.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords
// Barycentric weights of a 3D point against a 3D triangle, signed fixed point.
// Input channel item_valid/item_ready carries point P and vertices A, B, C;
// output channel result_valid/result_ready carries weight_u, weight_v,
// weight_w and degenerate. One result per input item, in order.
// Throughput is one item per clock unless a held result stalls the pipeline.
// The pipeline has three stages of dot products, five of wide products and
// numerators, one per quotient bit of the full-width divider (FRAC_BITS + 133),
// two to sign and combine the weights, and the output register.
// A zero denominator sets degenerate and returns all weights as zero.
// Reset clears every valid bit; data registers are not reset.
// While result_ready is low the held result stays put; the pipeline keeps
// taking items until an item reaches its last stage behind the held result.
// ----------------------------------------------------------------------------
`include "triangle_barycentric_coords_defines.svh"

module triangle_barycentric_coords
  import tbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  coord_t point_x,
  input  coord_t point_y,
  input  coord_t point_z,
  input  coord_t vert_a_x,
  input  coord_t vert_a_y,
  input  coord_t vert_a_z,
  input  coord_t vert_b_x,
  input  coord_t vert_b_y,
  input  coord_t vert_b_z,
  input  coord_t vert_c_x,
  input  coord_t vert_c_y,
  input  coord_t vert_c_z,
  output logic   result_valid,
  input  logic   result_ready,
  output coord_t weight_u,
  output coord_t weight_v,
  output coord_t weight_w,
  output logic   degenerate
);

  localparam int QUO_W = NUM_W - 1 + FRAC_BITS;
  localparam int SQ_W  = QUO_W + 1;
  localparam int SU_W  = QUO_W + 3;
  localparam logic signed [SU_W-1:0] ONE = {{(SU_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic   adv;
  coord_t pt [3];
  coord_t va [3];
  coord_t vb [3];
  coord_t vc [3];
  logic   dot_valid;
  dot_t   d00, d01, d11, d20, d21;

  tbc_ctl_t                 dctl [QUO_W+1];
  wide_t                    ddiv [QUO_W+1];
  wide_t                    drv  [QUO_W+1];
  wide_t                    drw  [QUO_W+1];
  logic [QUO_W-1:0]         dqv  [QUO_W+1];
  logic [QUO_W-1:0]         dqw  [QUO_W+1];

  logic                     a_valid, a_degen, b_valid, b_degen;
  logic signed [SQ_W-1:0]   qv_a, qw_a;
  logic signed [SQ_W-1:0]   qv_mag, qw_mag;
  logic signed [SU_W-1:0]   u_b, v_b, w_b;
  logic                     any_weight;

  function automatic coord_t sat32(logic signed [SU_W-1:0] x);
    logic fits;
    fits = (&x[SU_W-1:COORD_W-1]) | ~(|x[SU_W-1:COORD_W-1]);
    if (fits) return x[COORD_W-1:0];
    return x[SU_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  // The pipeline moves unless its last item has nowhere to go.
  assign adv        = ~b_valid | ~result_valid | result_ready;
  assign item_ready = adv;

  assign pt[0] = point_x;   assign pt[1] = point_y;   assign pt[2] = point_z;
  assign va[0] = vert_a_x;  assign va[1] = vert_a_y;  assign va[2] = vert_a_z;
  assign vb[0] = vert_b_x;  assign vb[1] = vert_b_y;  assign vb[2] = vert_b_z;
  assign vc[0] = vert_c_x;  assign vc[1] = vert_c_y;  assign vc[2] = vert_c_z;

  tbc_dot u_dot (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .item_valid (item_valid),
    .pt         (pt),
    .va         (va),
    .vb         (vb),
    .vc         (vc),
    .dot_valid  (dot_valid),
    .d00        (d00),
    .d01        (d01),
    .d11        (d11),
    .d20        (d20),
    .d21        (d21)
  );

  tbc_cross #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .dot_valid (dot_valid),
    .d00       (d00),
    .d01       (d01),
    .d11       (d11),
    .d20       (d20),
    .d21       (d21),
    .ctl       (dctl[0]),
    .denom     (ddiv[0]),
    .num_v     (dqv[0]),
    .num_w     (dqw[0])
  );

  assign drv[0] = '0;
  assign drw[0] = '0;

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    tbc_div_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .ctl_in    (dctl[s]),
      .div_in    (ddiv[s]),
      .rem_v_in  (drv[s]),
      .rem_w_in  (drw[s]),
      .nq_v_in   (dqv[s]),
      .nq_w_in   (dqw[s]),
      .ctl_out   (dctl[s+1]),
      .div_out   (ddiv[s+1]),
      .rem_v_out (drv[s+1]),
      .rem_w_out (drw[s+1]),
      .nq_v_out  (dqv[s+1]),
      .nq_w_out  (dqw[s+1])
    );
  end

  assign qv_mag = $signed({1'b0, dqv[QUO_W]});
  assign qw_mag = $signed({1'b0, dqw[QUO_W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= dctl[QUO_W].valid;
      b_valid <= a_valid;
    end
    if (adv) begin
      a_degen <= dctl[QUO_W].degen;
      qv_a <= dctl[QUO_W].neg_v ? -qv_mag : qv_mag;
      qw_a <= dctl[QUO_W].neg_w ? -qw_mag : qw_mag;
      b_degen <= a_degen;
      u_b <= ONE - SU_W'(qv_a) - SU_W'(qw_a);
      v_b <= SU_W'(qv_a);
      w_b <= SU_W'(qw_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_valid && adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (b_valid && adv) begin
      degenerate <= b_degen;
      weight_u   <= b_degen ? '0 : sat32(u_b);
      weight_v   <= b_degen ? '0 : sat32(v_b);
      weight_w   <= b_degen ? '0 : sat32(w_b);
    end
  end

  assign any_weight = |{weight_u, weight_v, weight_w};

  `TBC_ASSERT_IMPL(a_degen_zero, clk, rst, result_valid && degenerate, !any_weight)
  `TBC_ASSERT_IMPL(a_hold_stall, clk, rst, result_valid && !result_ready && b_valid, !item_ready)
  `TBC_ASSERT_NEXT(a_load_out, clk, rst, b_valid && item_ready, result_valid)
  `TBC_ASSERT_IMPL(a_divisor, clk, rst, dctl[QUO_W].valid && !dctl[QUO_W].degen, ddiv[QUO_W] != '0)

endmodule

// File: test/triangle_barycentric_coords_tb.sv
// ----------------------------------------------------------------------------
// Testbench for triangle_barycentric_coords
// Drives point and vertex items through the valid/ready input channel. A
// scoreboard computes the expected weights with wide exact integer arithmetic
// and compares every result transfer with the oldest expected weight set.
// The source and the sink idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_barycentric_coords_tb
  import tbc_pkg::*;
();

  localparam int FRAC = 16;
  localparam int WW   = 192;
  localparam int NUM_RANDOM = 1030;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [WW-1:0] big_t;

  // Coordinates in port order: P xyz, A xyz, B xyz, C xyz.
  typedef struct {
    coord_t f[12];
  } query_t;

  typedef struct {
    coord_t u;
    coord_t v;
    coord_t w;
    logic   degen;
  } weights_t;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} phase_e;

  class bary_scoreboard;
    weights_t pending[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function coord_t clamp32(big_t x);
      big_t hi;
      big_t lo;
      hi = big_t'(COORD_MAX);
      lo = big_t'(COORD_MIN);
      if (x > hi) return COORD_MAX;
      if (x < lo) return COORD_MIN;
      return x[COORD_W-1:0];
    endfunction

    function weights_t solve_weights(query_t q);
      big_t e0[3], e1[3], e2[3];
      big_t d00, d01, d11, d20, d21, den, vq, wq, uq, scale;
      weights_t r;
      for (int k = 0; k < 3; k++) begin
        e0[k] = big_t'(q.f[6+k]) - big_t'(q.f[3+k]);
        e1[k] = big_t'(q.f[9+k]) - big_t'(q.f[3+k]);
        e2[k] = big_t'(q.f[k])   - big_t'(q.f[3+k]);
      end
      d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
      d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
      d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
      d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
      d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
      den = d00*d11 - d01*d01;
      if (den == 0) begin
        r.u = '0;
        r.v = '0;
        r.w = '0;
        r.degen = 1'b1;
        return r;
      end
      scale = big_t'(1) <<< FRAC;
      // Signed division truncates toward zero, as the hardware does.
      vq = ((d11*d20 - d01*d21) * scale) / den;
      wq = ((d00*d21 - d01*d20) * scale) / den;
      uq = scale - vq - wq;
      r.u = clamp32(uq);
      r.v = clamp32(vq);
      r.w = clamp32(wq);
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_query(query_t q);
      pending.push_back(solve_weights(q));
    endfunction

    function void check_weights(weights_t got);
      weights_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result u=%h v=%h w=%h degenerate=%b",
                 $time, got.u, got.v, got.w, got.degen);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.u !== exp_w.u) begin
        $display("%0t: weight_u expected %h actual %h", $time, exp_w.u, got.u);
        errors++;
      end
      if (got.v !== exp_w.v) begin
        $display("%0t: weight_v expected %h actual %h", $time, exp_w.v, got.v);
        errors++;
      end
      if (got.w !== exp_w.w) begin
        $display("%0t: weight_w expected %h actual %h", $time, exp_w.w, got.w);
        errors++;
      end
      if (got.degen !== exp_w.degen) begin
        $display("%0t: degenerate expected %b actual %b", $time, exp_w.degen,
                 got.degen);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   item_valid;
  logic   item_ready;
  coord_t coord_in[12];
  logic   result_valid;
  logic   result_ready;
  coord_t weight_u;
  coord_t weight_v;
  coord_t weight_w;
  logic   degenerate;

  bary_scoreboard sb;
  phase_e phase;
  bit     hold_req;

  triangle_barycentric_coords #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .point_x(coord_in[0]),
    .point_y(coord_in[1]),
    .point_z(coord_in[2]),
    .vert_a_x(coord_in[3]),
    .vert_a_y(coord_in[4]),
    .vert_a_z(coord_in[5]),
    .vert_b_x(coord_in[6]),
    .vert_b_y(coord_in[7]),
    .vert_b_z(coord_in[8]),
    .vert_c_x(coord_in[9]),
    .vert_c_y(coord_in[10]),
    .vert_c_z(coord_in[11]),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .weight_u(weight_u),
    .weight_v(weight_v),
    .weight_w(weight_w),
    .degenerate(degenerate)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Transfer monitors on both channels.
  always @(posedge clk) begin
    query_t q;
    weights_t got;
    if (!rst && item_valid && item_ready) begin
      foreach (coord_in[k]) q.f[k] = coord_in[k];
      sb.note_query(q);
    end
    if (!rst && result_valid && result_ready) begin
      got.u = weight_u;
      got.v = weight_v;
      got.w = weight_w;
      got.degen = degenerate;
      sb.check_weights(got);
    end
  end

  // Sink: stalls by phase, plus one long hold-off on request.
  always @(negedge clk) begin
    int held;
    if (rst) begin
      result_ready = 1'b0;
      held = 0;
    end else if (hold_req && held < HOLD_CYCLES) begin
      result_ready = 1'b0;
      held++;
    end else begin
      case (phase)
        PH_SINK_STALL: result_ready = ($urandom_range(99) >= 68);
        PH_BOTH:       result_ready = ($urandom_range(99) >= 14);
        default:       result_ready = 1'b1;
      endcase
    end
  end

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    int span;
    kind = $urandom_range(99);
    span = (kind < 50) ? (1 << 20) : (kind < 60) ? (1 << 8) : 0;
    foreach (q.f[k]) q.f[k] = rand_coord(span);
    if (kind >= 80 && kind < 90) begin
      // Degenerate: a repeated vertex, or a third vertex at 2B - A, collinear where that sum does not wrap.
      for (int k = 0; k < 3; k++) begin
        if (kind < 85) q.f[9+k] = q.f[3+k];
        else q.f[9+k] = q.f[6+k] + (q.f[6+k] - q.f[3+k]);
      end
    end else if (kind >= 90) begin
      // Tiny triangle far from the point drives the weights into saturation.
      for (int k = 0; k < 3; k++) begin
        q.f[6+k] = q.f[3+k] + coord_t'($urandom_range(3));
        q.f[9+k] = q.f[3+k] + coord_t'($urandom_range(3));
      end
    end
    return q;
  endfunction

  function automatic query_t make_query(coord_t p0, coord_t p1, coord_t p2,
                                        coord_t a0, coord_t a1, coord_t a2,
                                        coord_t b0, coord_t b1, coord_t b2,
                                        coord_t c0, coord_t c1, coord_t c2);
    query_t q;
    q.f = '{p0, p1, p2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_query(query_t q);
    int gap_pct;
    gap_pct = (phase == PH_SRC_IDLE) ? 68 : (phase == PH_BOTH) ? 14 : 0;
    while ($urandom_range(99) < gap_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    foreach (coord_in[k]) coord_in[k] = q.f[k];
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  localparam coord_t ONE = coord_t'(1 << FRAC);

  initial begin
    query_t directed[$];
    int wait_cycles;
    sb = new();
    phase = PH_FREE;
    hold_req = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    result_ready = 1'b0;
    foreach (coord_in[k]) coord_in[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All zero: degenerate.
    directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Unit triangle, point at each vertex and at the centroid.
    directed.push_back(make_query(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    directed.push_back(make_query(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    directed.push_back(make_query(0, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    directed.push_back(make_query(ONE/3, ONE/3, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // Point off the plane and outside the triangle.
    directed.push_back(make_query(-ONE, 2*ONE, 5*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    // Collinear vertices: degenerate.
    directed.push_back(make_query(ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE,
                                  2*ONE, 2*ONE, 2*ONE));
    // Extreme coordinates.
    directed.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MAX, COORD_MIN, COORD_MAX,
                                  COORD_MIN, COORD_MAX, COORD_MAX));
    directed.push_back(make_query(COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MIN, COORD_MAX));
    directed.push_back(make_query(COORD_MAX, COORD_MIN, 0, COORD_MIN, 0, 0,
                                  COORD_MAX, 0, 0, COORD_MIN, COORD_MAX, 0));
    directed.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // Smallest triangle, far point: weights saturate both ways.
    directed.push_back(make_query(COORD_MAX, COORD_MAX, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed.push_back(make_query(COORD_MIN, COORD_MAX, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed.push_back(make_query(COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    // Non-exact quotient, negative weights, truncation toward zero.
    directed.push_back(make_query(-1, 7, 3, 0, 0, 0, 3, 0, 0, 0, 7, 0));
    directed.push_back(make_query(ONE, -ONE, 1, 1, 2, 3, 7, -5, 11, -13, 17, 19));
    // Repeated vertex: degenerate.
    directed.push_back(make_query(5, 6, 7, 1, 2, 3, 1, 2, 3, 9, 9, 9));
    foreach (directed[i]) send_query(directed[i]);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      phase = phase_e'((i / 130) % 4);
      if (i == 520) hold_req = 1'b1;
      send_query(random_query());
    end
    item_valid = 1'b0;
    phase = PH_FREE;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
